@@ sv/dmwbc_pkg.sv @@
// Shared constants, payload types and memory port types of the write-back cache.
package dmwbc_pkg;

    localparam int LINE_COUNT     = 64;
    localparam int BYTES_PER_LINE = 8;
    localparam int MEMORY_BYTES   = 65536;

    localparam int ADDR_W     = 16;
    localparam int OFFSET_W   = $clog2(BYTES_PER_LINE);
    localparam int INDEX_W    = $clog2(LINE_COUNT);
    localparam int TAG_W      = ADDR_W - INDEX_W - OFFSET_W;
    localparam int LINE_W     = 8 * BYTES_PER_LINE;
    localparam int MEM_WORDS  = MEMORY_BYTES / BYTES_PER_LINE;
    localparam int MEM_ADDR_W = $clog2(MEM_WORDS);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        write_byte;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] read_address;
        logic [LINE_W-1:0] line_bytes;
        logic              was_hit;
        logic              dirty_flag;
    } rsp_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [LINE_W-1:0]     data;
    } bm_write_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
    } bm_read_t;

endpackage

@@ sv/direct_mapped_write_back_cache.sv @@
// Direct-mapped write-back byte cache of 64 lines of 8 bytes over an internal 64 KiB
// memory. A hit is accepted with the cache memory read, then tag compared and updated
// in LOOKUP; a miss adds FILL for the synchronous read of the backing memory, which is
// issued together with the write-back of the old line. One item is in work at a
// time; a finished read word waits in the output register while the next item is taken.
// After reset the block clears both memories, one backing word a cycle, and holds stall
// high until the whole backing memory is swept, before the first item.
module direct_mapped_write_back_cache (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dmwbc_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dmwbc_pkg::rsp_t   rsp
);

    localparam int TAG_W      = dmwbc_pkg::TAG_W;
    localparam int INDEX_W    = dmwbc_pkg::INDEX_W;
    localparam int OFFSET_W   = dmwbc_pkg::OFFSET_W;
    localparam int LINE_W     = dmwbc_pkg::LINE_W;
    localparam int ADDR_W     = dmwbc_pkg::ADDR_W;
    localparam int MEM_ADDR_W = dmwbc_pkg::MEM_ADDR_W;

    typedef struct packed {
        logic              dirty;
        logic [TAG_W-1:0]  tag;
        logic [LINE_W-1:0] data;
    } entry_t;

    typedef enum logic [1:0] {
        IDLE,
        LOOKUP,
        FILL
    } state_t;

    function automatic logic [LINE_W-1:0] merge_byte(
        input logic [LINE_W-1:0]   line,
        input logic [OFFSET_W-1:0] off,
        input logic [7:0]          value
    );
        logic [LINE_W-1:0] res;
        res = line;
        for (int i = 0; i < dmwbc_pkg::BYTES_PER_LINE; i++)
        begin
            if (off == OFFSET_W'(i))
            begin
                res[8*i +: 8] = value;
            end
        end
        return res;
    endfunction

    state_t                 state_reg;
    logic [MEM_ADDR_W:0]    clr_cnt_reg;
    logic                   rsp_valid_reg;
    dmwbc_pkg::rsp_t        rsp_reg;
    dmwbc_pkg::req_t        item_reg;
    entry_t                 entry_reg;

    entry_t                 cache_mem [dmwbc_pkg::LINE_COUNT];

    logic                   clearing;
    logic                   req_fire;
    logic                   rsp_free;
    logic                   is_read;
    logic                   hit;
    logic [TAG_W-1:0]       item_tag;
    logic [INDEX_W-1:0]     item_index;
    logic [OFFSET_W-1:0]    item_offset;
    logic [INDEX_W-1:0]     req_index;
    logic [LINE_W-1:0]      fill_data;

    logic                   cache_we;
    logic [INDEX_W-1:0]     cache_waddr;
    entry_t                 cache_wdata;
    dmwbc_pkg::bm_write_t   bm_wr;
    dmwbc_pkg::bm_read_t    bm_rd;
    logic                   done;
    logic                   emit;
    dmwbc_pkg::rsp_t        rsp_next;

    assign clearing    = !clr_cnt_reg[MEM_ADDR_W];
    assign req_stall   = clearing || (state_reg != IDLE);
    assign req_fire    = req_valid && !req_stall;
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    assign is_read     = (item_reg.command == dmwbc_pkg::CMD_READ);
    assign item_tag    = item_reg.byte_address[ADDR_W-1 -: TAG_W];
    assign item_index  = item_reg.byte_address[OFFSET_W +: INDEX_W];
    assign item_offset = item_reg.byte_address[OFFSET_W-1:0];
    assign req_index   = req.byte_address[OFFSET_W +: INDEX_W];
    assign hit         = (entry_reg.tag == item_tag);

    always_comb
    begin
        cache_we    = 1'b0;
        cache_waddr = item_index;
        cache_wdata = entry_reg;
        bm_wr       = '0;
        bm_rd       = '0;
        done        = 1'b0;
        emit        = 1'b0;
        rsp_next    = '0;
        rsp_next.read_address = item_reg.byte_address;

        if (clearing)
        begin
            // sweep both memories back to all zero
            cache_we    = 1'b1;
            cache_waddr = clr_cnt_reg[INDEX_W-1:0];
            cache_wdata = '0;
            bm_wr.en    = 1'b1;
            bm_wr.addr  = clr_cnt_reg[MEM_ADDR_W-1:0];
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                end
                LOOKUP:
                begin
                    if (hit)
                    begin
                        done                = !is_read || rsp_free;
                        emit                = is_read && rsp_free;
                        rsp_next.line_bytes = entry_reg.data;
                        rsp_next.was_hit    = 1'b1;
                        rsp_next.dirty_flag = entry_reg.dirty;
                        if (!is_read)
                        begin
                            cache_we         = 1'b1;
                            cache_wdata.data = merge_byte(entry_reg.data, item_offset,
                                                          item_reg.write_byte);
                            cache_wdata.dirty = 1'b1;
                        end
                    end
                    else
                    begin
                        // write back the resident line, fetch the addressed one
                        bm_wr.en   = 1'b1;
                        bm_wr.addr = {entry_reg.tag, item_index};
                        bm_wr.data = entry_reg.data;
                        bm_rd.en   = 1'b1;
                        bm_rd.addr = {item_tag, item_index};
                    end
                end
                FILL:
                begin
                    done                = !is_read || rsp_free;
                    emit                = is_read && rsp_free;
                    rsp_next.line_bytes = fill_data;
                    rsp_next.was_hit    = 1'b0;
                    rsp_next.dirty_flag = entry_reg.dirty;
                    cache_we            = done;
                    cache_wdata.tag     = item_tag;
                    cache_wdata.dirty   = !is_read;
                    cache_wdata.data    = is_read ? fill_data
                                        : merge_byte(fill_data, item_offset,
                                                     item_reg.write_byte);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
        begin
            cache_mem[cache_waddr] <= cache_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            entry_reg <= cache_mem[req_index];
        end
    end

    dmwbc_backing_mem #(
        .MEM_WORDS (dmwbc_pkg::MEM_WORDS)
    ) u_backing_mem (
        .clk     (clk),
        .wr      (bm_wr),
        .rd      (bm_rd),
        .rd_data (fill_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            item_reg      <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= rsp_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (req_fire)
                    begin
                        item_reg  <= req;
                        state_reg <= LOOKUP;
                    end
                end
                LOOKUP:
                begin
                    if (!hit)
                    begin
                        state_reg <= FILL;
                    end
                    else if (done)
                    begin
                        state_reg <= IDLE;
                    end
                end
                FILL:
                begin
                    if (done)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/dmwbc_backing_mem.sv @@
// Backing memory: one line per word, one write and one registered read per cycle.
module dmwbc_backing_mem #(
    parameter int MEM_WORDS = dmwbc_pkg::MEM_WORDS
) (
    input  logic                          clk,
    input  dmwbc_pkg::bm_write_t          wr,
    input  dmwbc_pkg::bm_read_t           rd,
    output logic [dmwbc_pkg::LINE_W-1:0]  rd_data
);

    logic [dmwbc_pkg::LINE_W-1:0] mem [MEM_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
